// ===== design/brs_pkg.sv =====
// shared types and constants for the bidomain refine/select engine
// used by brs_run and bidomain_refine_select_top; no dependencies
`timescale 1ns / 1ps

package brs_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_DOMAINS_DEF  = 64;
    localparam logic [6:0] NO_VERTEX   = 7'd64;
    localparam logic [6:0] BOUND_LIMIT = 7'd64;

    typedef enum logic [3:0] {
        ACT_WR_LEFT  = 4'd0,
        ACT_WR_RIGHT = 4'd1,
        ACT_APPEND   = 4'd2,
        ACT_CLEAR    = 4'd3,
        ACT_FILTER   = 4'd4,
        ACT_SELECT   = 4'd5,
        ACT_RD_LEFT  = 4'd6,
        ACT_RD_RIGHT = 4'd7,
        ACT_RD_DOM   = 4'd8
    } act_t;

    typedef enum logic [1:0] {
        RUN_WRITE = 2'd0,
        RUN_READ  = 2'd1,
        RUN_SPLIT = 2'd2,
        RUN_MIN   = 2'd3
    } run_op_t;

    typedef enum logic [2:0] {
        R_IDLE,
        R_STEP,
        R_CHKJ,
        R_CHKK,
        R_WRJ,
        R_RDWAIT
    } run_state_t;

    typedef enum logic [3:0] {
        T_IDLE,
        T_MOD,
        T_APPEND,
        T_RUNWAIT,
        T_DRD,
        T_FLT_RD,
        T_FLT_WAIT,
        T_FLT_LEFT,
        T_FLT_RIGHT,
        T_FLT_EMIT1,
        T_FLT_EMIT2,
        T_SEL_RD,
        T_SEL_WAIT,
        T_SEL_MIN,
        T_FINISH
    } state_t;

    typedef struct packed {
        logic       adj;
        logic [6:0] rl;
        logic [6:0] ll;
        logic [5:0] r;
        logic [5:0] l;
    } dom_t;

    typedef struct packed {
        logic        go;
        run_op_t     op;
        logic        side;
        logic [5:0]  start;
        logic [6:0]  len;
        logic [5:0]  vertex;
        logic [63:0] row;
    } run_req_t;

    typedef struct packed {
        logic       done;
        logic [6:0] result;
        logic [5:0] rdata;
    } run_resp_t;

    function automatic logic [6:0] min7(input logic [6:0] a, input logic [6:0] b);
        min7 = (a < b) ? a : b;
    endfunction

endpackage

// ===== design/brs_run.sv =====
// vertex arrays and run walker: array write/read, in-place split of a run, min scan
// depends on brs_pkg
`timescale 1ns / 1ps

module brs_run #(
    parameter int MAX_VERTICES = brs_pkg::MAX_VERTICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  brs_pkg::run_req_t  req,
    output brs_pkg::run_resp_t resp
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [5:0] lmem [MAX_VERTICES];
    logic [5:0] rmem [MAX_VERTICES];
    logic [5:0] rd_l, rd_r;

    brs_pkg::run_state_t st_reg, st_next;
    brs_pkg::run_op_t    op_reg, op_next;
    logic        side_reg, side_next;
    logic [63:0] row_reg, row_next;
    logic [5:0]  pj_reg, pj_next, pk_reg, pk_next;
    logic [6:0]  cnt_reg, cnt_next, kept_reg, kept_next, min_reg, min_next;
    logic [5:0]  vj_reg, vj_next, vk_reg, vk_next;
    logic        done_reg, done_next;
    logic [6:0]  result_reg, result_next;
    logic [5:0]  rdata_reg, rdata_next;

    logic          we, wside;
    logic [VW-1:0] wa, ra;
    logic [5:0]    wd, v;

    function automatic logic [5:0] inc_pos(input logic [5:0] p);
        inc_pos = (p == 6'(MAX_VERTICES - 1)) ? 6'd0 : p + 6'd1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (we && !wside)
        begin
            lmem[wa] <= wd;
        end
        if (we && wside)
        begin
            rmem[wa] <= wd;
        end
        rd_l <= lmem[ra];
        rd_r <= rmem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= brs_pkg::R_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        side_reg   <= side_next;
        row_reg    <= row_next;
        pj_reg     <= pj_next;
        pk_reg     <= pk_next;
        cnt_reg    <= cnt_next;
        kept_reg   <= kept_next;
        min_reg    <= min_next;
        vj_reg     <= vj_next;
        vk_reg     <= vk_next;
        result_reg <= result_next;
        rdata_reg  <= rdata_next;
    end

    always_comb
    begin
        st_next     = st_reg;
        op_next     = op_reg;
        side_next   = side_reg;
        row_next    = row_reg;
        pj_next     = pj_reg;
        pk_next     = pk_reg;
        cnt_next    = cnt_reg;
        kept_next   = kept_reg;
        min_next    = min_reg;
        vj_next     = vj_reg;
        vk_next     = vk_reg;
        result_next = result_reg;
        rdata_next  = rdata_reg;
        done_next   = 1'b0;
        we          = 1'b0;
        wside       = side_reg;
        wa          = pj_reg[VW-1:0];
        wd          = vj_reg;
        ra          = pj_reg[VW-1:0];
        v           = side_reg ? rd_r : rd_l;

        case (st_reg)
            brs_pkg::R_IDLE:
            begin
                if (req.go)
                begin
                    op_next   = req.op;
                    side_next = req.side;
                    row_next  = req.row;
                    pj_next   = req.start;
                    pk_next   = req.start;
                    cnt_next  = req.len;
                    kept_next = 7'd0;
                    min_next  = brs_pkg::NO_VERTEX;
                    case (req.op)
                        brs_pkg::RUN_WRITE:
                        begin
                            we        = 1'b1;
                            wside     = req.side;
                            wa        = req.start[VW-1:0];
                            wd        = req.vertex;
                            done_next = 1'b1;
                        end
                        brs_pkg::RUN_READ:
                        begin
                            ra      = req.start[VW-1:0];
                            st_next = brs_pkg::R_RDWAIT;
                        end
                        default:
                        begin
                            st_next = brs_pkg::R_STEP;
                        end
                    endcase
                end
            end
            brs_pkg::R_STEP:
            begin
                if (cnt_reg == 7'd0)
                begin
                    result_next = (op_reg == brs_pkg::RUN_MIN) ? min_reg : kept_reg;
                    done_next   = 1'b1;
                    st_next     = brs_pkg::R_IDLE;
                end
                else
                begin
                    st_next = brs_pkg::R_CHKJ;
                end
            end
            brs_pkg::R_CHKJ:
            begin
                if (op_reg == brs_pkg::RUN_MIN)
                begin
                    if ({1'b0, v} < min_reg)
                    begin
                        min_next = {1'b0, v};
                    end
                    pj_next  = inc_pos(pj_reg);
                    cnt_next = cnt_reg - 7'd1;
                    st_next  = brs_pkg::R_STEP;
                end
                else if (row_reg[v])
                begin
                    if (pk_reg == pj_reg)
                    begin
                        kept_next = kept_reg + 7'd1;
                        pk_next   = inc_pos(pk_reg);
                        pj_next   = inc_pos(pj_reg);
                        cnt_next  = cnt_reg - 7'd1;
                        st_next   = brs_pkg::R_STEP;
                    end
                    else
                    begin
                        // fetch the entry at the write pointer for the swap
                        vj_next = v;
                        ra      = pk_reg[VW-1:0];
                        st_next = brs_pkg::R_CHKK;
                    end
                end
                else
                begin
                    pj_next  = inc_pos(pj_reg);
                    cnt_next = cnt_reg - 7'd1;
                    st_next  = brs_pkg::R_STEP;
                end
            end
            brs_pkg::R_CHKK:
            begin
                we      = 1'b1;
                wa      = pk_reg[VW-1:0];
                wd      = vj_reg;
                vk_next = v;
                st_next = brs_pkg::R_WRJ;
            end
            brs_pkg::R_WRJ:
            begin
                we        = 1'b1;
                wa        = pj_reg[VW-1:0];
                wd        = vk_reg;
                kept_next = kept_reg + 7'd1;
                pk_next   = inc_pos(pk_reg);
                pj_next   = inc_pos(pj_reg);
                cnt_next  = cnt_reg - 7'd1;
                st_next   = brs_pkg::R_STEP;
            end
            brs_pkg::R_RDWAIT:
            begin
                rdata_next = v;
                done_next  = 1'b1;
                st_next    = brs_pkg::R_IDLE;
            end
            default:
            begin
                st_next = brs_pkg::R_IDLE;
            end
        endcase
    end

    assign resp.done   = done_reg;
    assign resp.result = result_reg;
    assign resp.rdata  = rdata_reg;

endmodule

// ===== design/bidomain_refine_select_top.sv =====
// top level of the bidomain refine/select engine: domain table and sequencer
// depends on brs_pkg and brs_run
//
//  channel   | handshake                 | fields
//  ----------+---------------------------+-----------------------------------------
//  command   | start, busy               | action .. matching_size
//  result    | done (one-cycle strobe)   | error .. out_adjacent
//
// append first brings each start into the array range by repeated subtraction; filter
// splits the left and right runs of every domain in turn, moving kept vertices to the
// front of each run by swaps, and writes the non-edge and edge parts to the other bank;
// select skips ineligible domains and scans the left run of each eligible one for its
// smallest vertex.
// reset clears the table count and bank; the arrays hold garbage until written.
// busy stays high from accept until the done strobe; results cannot be stalled.
`timescale 1ns / 1ps

module bidomain_refine_select_top #(
    parameter int MAX_VERTICES = brs_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DOMAINS  = brs_pkg::MAX_DOMAINS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [3:0]  action,
    input  logic [5:0]  index,
    input  logic [5:0]  vertex,
    input  logic [5:0]  dom_left_start,
    input  logic [5:0]  dom_right_start,
    input  logic [6:0]  dom_left_len,
    input  logic [6:0]  dom_right_len,
    input  logic        dom_adjacent,
    input  logic [63:0] left_adj_row,
    input  logic [63:0] right_adj_row,
    input  logic        connected_only,
    input  logic [6:0]  matching_size,
    output logic        error,
    output logic        best_found,
    output logic [5:0]  best_index,
    output logic [6:0]  domain_count,
    output logic [6:0]  bound,
    output logic [5:0]  read_vertex,
    output logic [5:0]  out_left_start,
    output logic [5:0]  out_right_start,
    output logic [6:0]  out_left_len,
    output logic [6:0]  out_right_len,
    output logic        out_adjacent
);

    localparam int DW = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
    localparam logic [6:0] MV7 = 7'(MAX_VERTICES);
    localparam logic [6:0] MD7 = 7'(MAX_DOMAINS);

    brs_pkg::dom_t dmem [2][MAX_DOMAINS];
    brs_pkg::dom_t drdata, dwdata;
    logic          dwe, dwbank;
    logic [DW-1:0] dwaddr, draddr;

    brs_pkg::run_req_t  run_req;
    brs_pkg::run_resp_t run_resp;

    brs_pkg::state_t st_reg, st_next;
    logic        done_reg, done_next;
    logic        bank_reg, bank_next;
    logic [6:0]  held_reg, held_next;
    logic [12:0] total_reg, total_next;

    brs_pkg::act_t act_reg, act_next;
    logic [5:0]  ls_reg, ls_next, rs_reg, rs_next;
    logic [6:0]  ll_reg, ll_next, rl_reg, rl_next;
    logic        adj_reg, adj_next, only_adj_reg, only_adj_next;
    logic [63:0] lrow_reg, lrow_next, rrow_reg, rrow_next;

    brs_pkg::dom_t cur_reg, cur_next;
    logic [6:0]  i_reg, i_next, n_reg, n_next;
    logic [12:0] ntot_reg, ntot_next;
    logic        over_reg, over_next;
    logic [6:0]  le_reg, le_next, re_reg, re_next;
    logic [6:0]  big_reg, big_next, minsz_reg, minsz_next, mintie_reg, mintie_next;

    logic        err_reg, err_next, found_reg, found_next;
    logic [5:0]  bidx_reg, bidx_next, rv_reg, rv_next;
    brs_pkg::dom_t od_reg, od_next;

    logic [6:0]  ln, rn, lsum, rsum, big_cur;
    logic [5:0]  wrap_l, wrap_r;

    brs_run #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_run (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (run_req),
        .resp (run_resp)
    );

    always_ff @(posedge clk)
    begin
        if (dwe)
        begin
            dmem[dwbank][dwaddr] <= dwdata;
        end
        drdata <= dmem[bank_reg][draddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= brs_pkg::T_IDLE;
            done_reg  <= 1'b0;
            bank_reg  <= 1'b0;
            held_reg  <= 7'd0;
            total_reg <= 13'd0;
        end
        else
        begin
            st_reg    <= st_next;
            done_reg  <= done_next;
            bank_reg  <= bank_next;
            held_reg  <= held_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        ls_reg       <= ls_next;
        rs_reg       <= rs_next;
        ll_reg       <= ll_next;
        rl_reg       <= rl_next;
        adj_reg      <= adj_next;
        only_adj_reg <= only_adj_next;
        lrow_reg     <= lrow_next;
        rrow_reg     <= rrow_next;
        cur_reg      <= cur_next;
        i_reg        <= i_next;
        n_reg        <= n_next;
        ntot_reg     <= ntot_next;
        over_reg     <= over_next;
        le_reg       <= le_next;
        re_reg       <= re_next;
        big_reg      <= big_next;
        minsz_reg    <= minsz_next;
        mintie_reg   <= mintie_next;
        err_reg      <= err_next;
        found_reg    <= found_next;
        bidx_reg     <= bidx_next;
        rv_reg       <= rv_next;
        od_reg       <= od_next;
    end

    // split geometry of the current domain
    assign ln      = cur_reg.ll - le_reg;
    assign rn      = cur_reg.rl - re_reg;
    assign lsum    = {1'b0, cur_reg.l} + le_reg;
    assign rsum    = {1'b0, cur_reg.r} + re_reg;
    assign wrap_l  = (lsum >= MV7) ? 6'(lsum - MV7) : lsum[5:0];
    assign wrap_r  = (rsum >= MV7) ? 6'(rsum - MV7) : rsum[5:0];
    assign big_cur = (drdata.ll > drdata.rl) ? drdata.ll : drdata.rl;

    always_comb
    begin
        st_next       = st_reg;
        done_next     = 1'b0;
        bank_next     = bank_reg;
        held_next     = held_reg;
        total_next    = total_reg;
        act_next      = act_reg;
        ls_next       = ls_reg;
        rs_next       = rs_reg;
        ll_next       = ll_reg;
        rl_next       = rl_reg;
        adj_next      = adj_reg;
        only_adj_next = only_adj_reg;
        lrow_next     = lrow_reg;
        rrow_next     = rrow_reg;
        cur_next      = cur_reg;
        i_next        = i_reg;
        n_next        = n_reg;
        ntot_next     = ntot_reg;
        over_next     = over_reg;
        le_next       = le_reg;
        re_next       = re_reg;
        big_next      = big_reg;
        minsz_next    = minsz_reg;
        mintie_next   = mintie_reg;
        err_next      = err_reg;
        found_next    = found_reg;
        bidx_next     = bidx_reg;
        rv_next       = rv_reg;
        od_next       = od_reg;

        dwe    = 1'b0;
        dwbank = ~bank_reg;
        dwaddr = n_reg[DW-1:0];
        dwdata = '0;
        draddr = i_reg[DW-1:0];

        run_req        = '0;
        run_req.op     = brs_pkg::RUN_SPLIT;
        run_req.vertex = vertex;

        case (st_reg)
            brs_pkg::T_IDLE:
            begin
                if (start)
                begin
                    act_next      = brs_pkg::act_t'(action);
                    ls_next       = dom_left_start;
                    rs_next       = dom_right_start;
                    ll_next       = (dom_left_len > MV7) ? MV7 : dom_left_len;
                    rl_next       = (dom_right_len > MV7) ? MV7 : dom_right_len;
                    adj_next      = dom_adjacent;
                    only_adj_next = connected_only && (matching_size != 7'd0);
                    lrow_next     = left_adj_row;
                    rrow_next     = right_adj_row;
                    i_next        = 7'd0;
                    n_next        = 7'd0;
                    ntot_next     = 13'd0;
                    over_next     = 1'b0;
                    err_next      = 1'b0;
                    found_next    = 1'b0;
                    bidx_next     = 6'd0;
                    rv_next       = 6'd0;
                    od_next       = '0;
                    st_next       = brs_pkg::T_FINISH;
                    case (brs_pkg::act_t'(action))
                        brs_pkg::ACT_WR_LEFT, brs_pkg::ACT_WR_RIGHT:
                        begin
                            if ({1'b0, index} < MV7)
                            begin
                                run_req.go    = 1'b1;
                                run_req.op    = brs_pkg::RUN_WRITE;
                                run_req.side  = (brs_pkg::act_t'(action) == brs_pkg::ACT_WR_RIGHT);
                                run_req.start = index;
                                st_next       = brs_pkg::T_RUNWAIT;
                            end
                        end
                        brs_pkg::ACT_RD_LEFT, brs_pkg::ACT_RD_RIGHT:
                        begin
                            if ({1'b0, index} < MV7)
                            begin
                                run_req.go    = 1'b1;
                                run_req.op    = brs_pkg::RUN_READ;
                                run_req.side  = (brs_pkg::act_t'(action) == brs_pkg::ACT_RD_RIGHT);
                                run_req.start = index;
                                st_next       = brs_pkg::T_RUNWAIT;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        brs_pkg::ACT_APPEND:
                        begin
                            if (held_reg < MD7)
                            begin
                                st_next = brs_pkg::T_MOD;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        brs_pkg::ACT_CLEAR:
                        begin
                            held_next  = 7'd0;
                            total_next = 13'd0;
                        end
                        brs_pkg::ACT_FILTER:
                        begin
                            st_next = brs_pkg::T_FLT_RD;
                        end
                        brs_pkg::ACT_SELECT:
                        begin
                            st_next = brs_pkg::T_SEL_RD;
                        end
                        brs_pkg::ACT_RD_DOM:
                        begin
                            if ({1'b0, index} < held_reg)
                            begin
                                draddr  = index[DW-1:0];
                                st_next = brs_pkg::T_DRD;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            st_next = brs_pkg::T_FINISH;
                        end
                    endcase
                end
            end
            brs_pkg::T_MOD:
            begin
                // bring the starts into the array range one subtract a cycle
                if ({1'b0, ls_reg} >= MV7)
                begin
                    ls_next = 6'({1'b0, ls_reg} - MV7);
                end
                if ({1'b0, rs_reg} >= MV7)
                begin
                    rs_next = 6'({1'b0, rs_reg} - MV7);
                end
                if (({1'b0, ls_reg} < MV7) && ({1'b0, rs_reg} < MV7))
                begin
                    st_next = brs_pkg::T_APPEND;
                end
            end
            brs_pkg::T_APPEND:
            begin
                dwe        = 1'b1;
                dwbank     = bank_reg;
                dwaddr     = held_reg[DW-1:0];
                dwdata     = '{adj: adj_reg, rl: rl_reg, ll: ll_reg, r: rs_reg, l: ls_reg};
                held_next  = held_reg + 7'd1;
                total_next = total_reg + 13'(brs_pkg::min7(ll_reg, rl_reg));
                st_next    = brs_pkg::T_FINISH;
            end
            brs_pkg::T_RUNWAIT:
            begin
                if (run_resp.done)
                begin
                    if (act_reg == brs_pkg::ACT_RD_LEFT || act_reg == brs_pkg::ACT_RD_RIGHT)
                    begin
                        rv_next = run_resp.rdata;
                    end
                    st_next = brs_pkg::T_FINISH;
                end
            end
            brs_pkg::T_DRD:
            begin
                od_next = drdata;
                st_next = brs_pkg::T_FINISH;
            end
            brs_pkg::T_FLT_RD:
            begin
                if (i_reg == held_reg)
                begin
                    bank_next  = ~bank_reg;
                    held_next  = n_reg;
                    total_next = ntot_reg;
                    err_next   = over_reg;
                    st_next    = brs_pkg::T_FINISH;
                end
                else
                begin
                    st_next = brs_pkg::T_FLT_WAIT;
                end
            end
            brs_pkg::T_FLT_WAIT:
            begin
                cur_next      = drdata;
                run_req.go    = 1'b1;
                run_req.op    = brs_pkg::RUN_SPLIT;
                run_req.side  = 1'b0;
                run_req.start = drdata.l;
                run_req.len   = drdata.ll;
                run_req.row   = lrow_reg;
                st_next       = brs_pkg::T_FLT_LEFT;
            end
            brs_pkg::T_FLT_LEFT:
            begin
                if (run_resp.done)
                begin
                    le_next       = run_resp.result;
                    run_req.go    = 1'b1;
                    run_req.op    = brs_pkg::RUN_SPLIT;
                    run_req.side  = 1'b1;
                    run_req.start = cur_reg.r;
                    run_req.len   = cur_reg.rl;
                    run_req.row   = rrow_reg;
                    st_next       = brs_pkg::T_FLT_RIGHT;
                end
            end
            brs_pkg::T_FLT_RIGHT:
            begin
                if (run_resp.done)
                begin
                    re_next = run_resp.result;
                    st_next = brs_pkg::T_FLT_EMIT1;
                end
            end
            brs_pkg::T_FLT_EMIT1:
            begin
                // non-edge part first, keeping the old mark
                if (ln != 7'd0 && rn != 7'd0)
                begin
                    if (n_reg < MD7)
                    begin
                        dwe       = 1'b1;
                        dwdata    = '{adj: cur_reg.adj, rl: rn, ll: ln, r: wrap_r, l: wrap_l};
                        n_next    = n_reg + 7'd1;
                        ntot_next = ntot_reg + 13'(brs_pkg::min7(ln, rn));
                    end
                    else
                    begin
                        over_next = 1'b1;
                    end
                end
                st_next = brs_pkg::T_FLT_EMIT2;
            end
            brs_pkg::T_FLT_EMIT2:
            begin
                if (le_reg != 7'd0 && re_reg != 7'd0)
                begin
                    if (n_reg < MD7)
                    begin
                        dwe       = 1'b1;
                        dwdata    = '{adj: 1'b1, rl: re_reg, ll: le_reg,
                                      r: cur_reg.r, l: cur_reg.l};
                        n_next    = n_reg + 7'd1;
                        ntot_next = ntot_reg + 13'(brs_pkg::min7(le_reg, re_reg));
                    end
                    else
                    begin
                        over_next = 1'b1;
                    end
                end
                i_next  = i_reg + 7'd1;
                st_next = brs_pkg::T_FLT_RD;
            end
            brs_pkg::T_SEL_RD:
            begin
                if (i_reg == held_reg)
                begin
                    st_next = brs_pkg::T_FINISH;
                end
                else
                begin
                    st_next = brs_pkg::T_SEL_WAIT;
                end
            end
            brs_pkg::T_SEL_WAIT:
            begin
                cur_next = drdata;
                if (only_adj_reg && !drdata.adj)
                begin
                    i_next  = i_reg + 7'd1;
                    st_next = brs_pkg::T_SEL_RD;
                end
                else
                begin
                    big_next      = big_cur;
                    run_req.go    = 1'b1;
                    run_req.op    = brs_pkg::RUN_MIN;
                    run_req.side  = 1'b0;
                    run_req.start = drdata.l;
                    run_req.len   = drdata.ll;
                    st_next       = brs_pkg::T_SEL_MIN;
                end
            end
            brs_pkg::T_SEL_MIN:
            begin
                if (run_resp.done)
                begin
                    if (!found_reg || big_reg < minsz_reg ||
                        (big_reg == minsz_reg && run_resp.result < mintie_reg))
                    begin
                        found_next  = 1'b1;
                        minsz_next  = big_reg;
                        mintie_next = run_resp.result;
                        bidx_next   = i_reg[5:0];
                    end
                    i_next  = i_reg + 7'd1;
                    st_next = brs_pkg::T_SEL_RD;
                end
            end
            brs_pkg::T_FINISH:
            begin
                done_next = 1'b1;
                st_next   = brs_pkg::T_IDLE;
            end
            default:
            begin
                st_next = brs_pkg::T_IDLE;
            end
        endcase
    end

    assign busy            = (st_reg != brs_pkg::T_IDLE);
    assign done            = done_reg;
    assign error           = err_reg;
    assign best_found      = found_reg;
    assign best_index      = bidx_reg;
    assign domain_count    = held_reg;
    assign bound           = (total_reg > 13'(brs_pkg::BOUND_LIMIT)) ? brs_pkg::BOUND_LIMIT
                                                                    : total_reg[6:0];
    assign read_vertex     = rv_reg;
    assign out_left_start  = od_reg.l;
    assign out_right_start = od_reg.r;
    assign out_left_len    = od_reg.ll;
    assign out_right_len   = od_reg.rl;
    assign out_adjacent    = od_reg.adj;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= MD7)
        else $error("domain count beyond table size");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

// ===== bench/tb_bidomain_refine_select_top.sv =====
// self-checking bench for bidomain_refine_select_top: a queued command driver,
// a result monitor and an in-bench prediction of the domain table engine
// depends on brs_pkg and the design sources under design/
`timescale 1ns / 1ps

module tb_bidomain_refine_select_top;

    localparam int N_ITEMS = 1700;
    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [3:0] ACT_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] ACT_UNUSED_LAST  = 4'd15;

    typedef struct {
        logic [3:0]  action;
        logic [5:0]  index;
        logic [5:0]  vertex;
        logic [5:0]  dls;
        logic [5:0]  drs;
        logic [6:0]  dll;
        logic [6:0]  drl;
        logic        dadj;
        logic [63:0] lrow;
        logic [63:0] rrow;
        logic        conn;
        logic [6:0]  msize;
    } cmd_t;

    typedef struct packed {
        logic       error;
        logic       best_found;
        logic [5:0] best_index;
        logic [6:0] domain_count;
        logic [6:0] bound;
        logic [5:0] read_vertex;
        logic [5:0] out_left_start;
        logic [5:0] out_right_start;
        logic [6:0] out_left_len;
        logic [6:0] out_right_len;
        logic       out_adjacent;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy, done;
    logic [3:0]  action = '0;
    logic [5:0]  index = '0, vertex = '0, dom_left_start = '0, dom_right_start = '0;
    logic [6:0]  dom_left_len = '0, dom_right_len = '0, matching_size = '0;
    logic        dom_adjacent = 1'b0, connected_only = 1'b0;
    logic [63:0] left_adj_row = '0, right_adj_row = '0;
    logic        error, best_found, out_adjacent;
    logic [5:0]  best_index, read_vertex, out_left_start, out_right_start;
    logic [6:0]  domain_count, bound, out_left_len, out_right_len;

    bidomain_refine_select_top dut (.*);

    always #10 clk = ~clk;

    // predicted engine state
    logic [5:0]    left_arr [64];
    logic [5:0]    right_arr [64];
    brs_pkg::dom_t dom_bank [2][64];
    logic          live_bank = 1'b0;
    logic [6:0]    held = '0;

    cmd_t     pending_cmds[$];
    outcome_t expected_outcomes[$];
    bit       stim_done = 1'b0;
    int       mismatches = 0, beats_checked = 0, filters_sent = 0, selects_sent = 0;
    int       cycles = 0;

    function automatic logic [6:0] partition_run(bit right_side, logic [5:0] st,
                                                 logic [6:0] len, logic [63:0] row);
        logic [6:0] kept;
        logic [5:0] pj, pk, t;
        kept = '0;
        for (int j = 0; j < len; j++)
        begin
            pj = st + 6'(j);
            pk = st + kept[5:0];
            if (right_side)
            begin
                if (row[right_arr[pj]])
                begin
                    t = right_arr[pk]; right_arr[pk] = right_arr[pj]; right_arr[pj] = t;
                    kept++;
                end
            end
            else if (row[left_arr[pj]])
            begin
                t = left_arr[pk]; left_arr[pk] = left_arr[pj]; left_arr[pj] = t;
                kept++;
            end
        end
        return kept;
    endfunction

    function automatic logic [6:0] table_bound();
        int sum;
        sum = 0;
        for (int i = 0; i < held; i++)
        begin
            brs_pkg::dom_t d;
            d = dom_bank[live_bank][i];
            sum += (d.ll < d.rl) ? d.ll : d.rl;
            if (sum > 64) sum = 64;
        end
        return 7'(sum);
    endfunction

    function automatic outcome_t predict_outcome(cmd_t c);
        outcome_t o;
        brs_pkg::dom_t d;
        logic nb, only_adj;
        logic [6:0] n, le, re, big, tie, min_big, min_tie;
        o = '0;
        case (c.action)
            brs_pkg::ACT_WR_LEFT:  left_arr[c.index] = c.vertex;
            brs_pkg::ACT_WR_RIGHT: right_arr[c.index] = c.vertex;
            brs_pkg::ACT_APPEND:
                if (held < 64)
                begin
                    d.l = c.dls; d.r = c.drs; d.adj = c.dadj;
                    d.ll = (c.dll > 64) ? 7'd64 : c.dll;
                    d.rl = (c.drl > 64) ? 7'd64 : c.drl;
                    dom_bank[live_bank][held] = d;
                    held++;
                end
                else o.error = 1'b1;
            brs_pkg::ACT_CLEAR: held = '0;
            brs_pkg::ACT_FILTER:
            begin
                nb = ~live_bank;
                n = '0;
                for (int i = 0; i < held; i++)
                begin
                    d = dom_bank[live_bank][i];
                    le = partition_run(1'b0, d.l, d.ll, c.lrow);
                    re = partition_run(1'b1, d.r, d.rl, c.rrow);
                    if (d.ll != le && d.rl != re)
                    begin
                        if (n < 64)
                        begin
                            dom_bank[nb][n] = '{adj: d.adj, rl: d.rl - re, ll: d.ll - le,
                                                r: d.r + re[5:0], l: d.l + le[5:0]};
                            n++;
                        end
                        else o.error = 1'b1;
                    end
                    if (le != 0 && re != 0)
                    begin
                        if (n < 64)
                        begin
                            dom_bank[nb][n] = '{adj: 1'b1, rl: re, ll: le, r: d.r, l: d.l};
                            n++;
                        end
                        else o.error = 1'b1;
                    end
                end
                live_bank = nb;
                held = n;
            end
            brs_pkg::ACT_SELECT:
            begin
                only_adj = c.conn && c.msize != 0;
                min_big = '0; min_tie = '0;
                for (int i = 0; i < held; i++)
                begin
                    d = dom_bank[live_bank][i];
                    if (!(only_adj && !d.adj))
                    begin
                        big = (d.ll > d.rl) ? d.ll : d.rl;
                        tie = brs_pkg::NO_VERTEX;
                        for (int j = 0; j < d.ll; j++)
                            if (left_arr[d.l + 6'(j)] < tie) tie = left_arr[d.l + 6'(j)];
                        if (!o.best_found || big < min_big || (big == min_big && tie < min_tie))
                        begin
                            o.best_found = 1'b1;
                            min_big = big; min_tie = tie;
                            o.best_index = 6'(i);
                        end
                    end
                end
            end
            brs_pkg::ACT_RD_LEFT:  o.read_vertex = left_arr[c.index];
            brs_pkg::ACT_RD_RIGHT: o.read_vertex = right_arr[c.index];
            brs_pkg::ACT_RD_DOM:
                if (c.index < held)
                begin
                    d = dom_bank[live_bank][c.index];
                    o.out_left_start = d.l; o.out_right_start = d.r;
                    o.out_left_len = d.ll; o.out_right_len = d.rl; o.out_adjacent = d.adj;
                end
                else o.error = 1'b1;
            default: ;
        endcase
        o.domain_count = held;
        o.bound = table_bound();
        return o;
    endfunction

    function automatic cmd_t blank_cmd(logic [3:0] a);
        cmd_t c;
        c = '{action: a, index: 6'($urandom), vertex: 6'($urandom), dls: 6'($urandom),
              drs: 6'($urandom), dll: 7'($urandom), drl: 7'($urandom), dadj: 1'($urandom),
              lrow: {$urandom, $urandom}, rrow: {$urandom, $urandom},
              conn: 1'($urandom), msize: 7'($urandom)};
        return c;
    endfunction

    function automatic void push_append(logic [5:0] ls, logic [5:0] rs, logic [6:0] ll,
                                        logic [6:0] rl, logic adj);
        cmd_t c;
        c = blank_cmd(brs_pkg::ACT_APPEND);
        c.dls = ls; c.drs = rs; c.dll = ll; c.drl = rl; c.dadj = adj;
        pending_cmds.push_back(c);
    endfunction

    function automatic void push_filter(logic [63:0] lr, logic [63:0] rr);
        cmd_t c;
        c = blank_cmd(brs_pkg::ACT_FILTER);
        c.lrow = lr; c.rrow = rr;
        pending_cmds.push_back(c);
    endfunction

    function automatic logic [6:0] short_len();
        if ($urandom_range(0, 19) == 0) return 7'($urandom_range(9, 127));
        return 7'($urandom_range(0, 8));
    endfunction

    function automatic logic [63:0] pick_row();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // clear, build a table, up to three array writes, then one to four rounds of refine, pick and domain read
    function automatic void push_search_round(bit fill_table);
        cmd_t c;
        int ndom;
        pending_cmds.push_back(blank_cmd(brs_pkg::ACT_CLEAR));
        ndom = fill_table ? 66 : $urandom_range(1, 6);
        for (int i = 0; i < ndom; i++)
            if (fill_table)
                push_append(6'($urandom), 6'($urandom), 7'($urandom_range(1, 3)),
                            7'($urandom_range(1, 3)), 1'($urandom));
            else
                push_append(6'($urandom), 6'($urandom), short_len(), short_len(), 1'($urandom));
        for (int i = $urandom_range(0, 3); i > 0; i--)
            pending_cmds.push_back(blank_cmd($urandom_range(0, 1) ? brs_pkg::ACT_WR_RIGHT
                                                                  : brs_pkg::ACT_WR_LEFT));
        for (int r = $urandom_range(1, 4); r > 0; r--)
        begin
            push_filter(pick_row(), pick_row());
            pending_cmds.push_back(blank_cmd(brs_pkg::ACT_SELECT));
            c = blank_cmd(brs_pkg::ACT_RD_DOM);
            c.index = 6'($urandom_range(0, 9));
            pending_cmds.push_back(c);
        end
    endfunction

    initial
    begin
        cmd_t c;
        // every array entry gets a value before anything looks at it
        for (int i = 0; i < 64; i++)
        begin
            c = blank_cmd(brs_pkg::ACT_WR_LEFT); c.index = 6'(i); c.vertex = 6'(i ^ 6'h2a);
            pending_cmds.push_back(c);
            c = blank_cmd(brs_pkg::ACT_WR_RIGHT); c.index = 6'(i); c.vertex = 6'(63 - i);
            pending_cmds.push_back(c);
        end
        // extremes, each action, lengths past the vertex count, unused codes
        c = blank_cmd(brs_pkg::ACT_RD_DOM); c.index = 6'd0; pending_cmds.push_back(c);
        pending_cmds.push_back(blank_cmd(brs_pkg::ACT_SELECT));
        push_filter('1, '1);
        push_append(6'd63, 6'd63, 7'd127, 7'd64, 1'b0);
        push_append(6'd0, 6'd0, 7'd0, 7'd5, 1'b1);
        push_append(6'd60, 6'd2, 7'd8, 7'd8, 1'b0);
        c = blank_cmd(brs_pkg::ACT_RD_DOM); c.index = 6'd0; pending_cmds.push_back(c);
        c = blank_cmd(brs_pkg::ACT_RD_DOM); c.index = 6'd63; pending_cmds.push_back(c);
        c = blank_cmd(brs_pkg::ACT_SELECT); c.conn = 1'b1; c.msize = 7'd127;
        pending_cmds.push_back(c);
        c = blank_cmd(brs_pkg::ACT_SELECT); c.conn = 1'b1; c.msize = 7'd0;
        pending_cmds.push_back(c);
        push_filter(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        c = blank_cmd(brs_pkg::ACT_SELECT); c.conn = 1'b1; c.msize = 7'd1;
        pending_cmds.push_back(c);
        push_filter('0, '0);
        c = blank_cmd(brs_pkg::ACT_RD_LEFT); c.index = 6'd63; pending_cmds.push_back(c);
        c = blank_cmd(brs_pkg::ACT_RD_RIGHT); c.index = 6'd0; pending_cmds.push_back(c);
        pending_cmds.push_back(blank_cmd(ACT_UNUSED_FIRST));
        pending_cmds.push_back(blank_cmd(ACT_UNUSED_LAST));
        pending_cmds.push_back(blank_cmd(brs_pkg::ACT_CLEAR));
        c = blank_cmd(brs_pkg::ACT_RD_DOM); c.index = 6'd0; pending_cmds.push_back(c);
        // random part: mostly well-formed search rounds, some noise
        while (pending_cmds.size() < N_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                c = blank_cmd(4'($urandom));
                if (c.action == brs_pkg::ACT_APPEND)
                begin
                    c.dll = short_len(); c.drl = short_len();
                end
                pending_cmds.push_back(c);
            end
            else push_search_round($urandom_range(0, 24) == 0);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // command driver
    int  gap = 0;
    bit  calm = 1'b0;
    always @(posedge clk)
    begin
        cmd_t c;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_outcomes.push_back(predict_outcome(
                    '{action: action, index: index, vertex: vertex, dls: dom_left_start,
                      drs: dom_right_start, dll: dom_left_len, drl: dom_right_len,
                      dadj: dom_adjacent, lrow: left_adj_row, rrow: right_adj_row,
                      conn: connected_only, msize: matching_size}));
                if (action == brs_pkg::ACT_FILTER) filters_sent++;
                if (action == brs_pkg::ACT_SELECT) selects_sent++;
                start <= 1'b0;
                if ($urandom_range(0, 99) == 0) calm = ~calm;
                if (calm) gap = 0;
                else if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 200);
                else gap = $urandom_range(0, 3);
            end
            else if (!start)
            begin
                if (gap > 0) gap--;
                else if (pending_cmds.size() > 0)
                begin
                    c = pending_cmds.pop_front();
                    action <= c.action; index <= c.index; vertex <= c.vertex;
                    dom_left_start <= c.dls; dom_right_start <= c.drs;
                    dom_left_len <= c.dll; dom_right_len <= c.drl; dom_adjacent <= c.dadj;
                    left_adj_row <= c.lrow; right_adj_row <= c.rrow;
                    connected_only <= c.conn; matching_size <= c.msize;
                    start <= 1'b1;
                end
                else stim_done = 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        outcome_t want, got;
        if (rst_n && done)
        begin
            got = '{error, best_found, best_index, domain_count, bound, read_vertex,
                    out_left_start, out_right_start, out_left_len, out_right_len,
                    out_adjacent};
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                beats_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d mismatch\n  expected %p\n  actual   %p",
                                 beats_checked, want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done && !start);
        wait (expected_outcomes.size() == 0);
        repeat (200) @(posedge clk);
        $display("checked %0d result beats, %0d filters and %0d selects among them",
                 beats_checked, filters_sent, selects_sent);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_outcomes.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
